/* rtl/hjc_pkg.sv */
// hjc_pkg: shared widths, types and codes for the height to jet color unit.
// No dependencies; every other file of the block imports this package.
package hjc_pkg;

	// Field widths
	localparam int HEIGHT_BITS = 32;
	localparam int COLOR_BITS  = 16;

	// Divider numerator (at most M*dv) and the wider working width of the front end
	localparam int NUM_BITS  = HEIGHT_BITS + COLOR_BITS;
	localparam int WIDE_BITS = NUM_BITS + 2;

	// APB address width: two 32-bit registers at byte offsets 0 and 4
	localparam int PADDR_BITS = 3;

	// Register indexes (decoded from paddr[2])
	localparam logic REG_HEIGHT_MIN = 1'b0;
	localparam logic REG_HEIGHT_MAX = 1'b1;

	typedef logic signed [HEIGHT_BITS-1:0] height_t;
	typedef logic [COLOR_BITS-1:0]         color_t;
	typedef logic [1:0]                    seg_t;

	localparam color_t  COLOR_MAX       = {COLOR_BITS{1'b1}};
	localparam height_t HEIGHT_MIN_RST  = '0;
	localparam height_t HEIGHT_MAX_RST  = HEIGHT_BITS'(65535);

	// Ramp segments: 4d below dv, 2dv, 3dv, or above
	localparam seg_t SEG_RISE_G = 2'd0;
	localparam seg_t SEG_FALL_B = 2'd1;
	localparam seg_t SEG_RISE_R = 2'd2;
	localparam seg_t SEG_FALL_G = 2'd3;

	// Data that moves from one divider cell to the next
	typedef struct packed {
		logic [HEIGHT_BITS-1:0] rem;     // partial remainder, below dv
		logic [COLOR_BITS-1:0]  num_lo;  // numerator bits not yet shifted in
		logic [HEIGHT_BITS-1:0] dv;      // divisor, max - min
		color_t                 quo;     // quotient bits so far
		seg_t                   seg;
		logic                   err;
	} cell_t;

endpackage

/* rtl/hjc_if.sv */
// hjc_if: valid/ready channel interfaces for height input and color output beats.
// Depends on hjc_pkg.
interface hjc_height_if import hjc_pkg::*; ();
	logic    valid;
	logic    ready;
	height_t height_raw;

	modport source (output valid, output height_raw, input ready);
	modport sink   (input valid, input height_raw, output ready);
endinterface

interface hjc_color_if import hjc_pkg::*; ();
	logic   valid;
	logic   ready;
	color_t red_level;
	color_t green_level;
	color_t blue_level;
	logic   range_error;

	modport source (output valid, output red_level, output green_level,
		output blue_level, output range_error, input ready);
	modport sink   (input valid, input red_level, input green_level,
		input blue_level, input range_error, output ready);
endinterface

/* rtl/hjc_cfg.sv */
// hjc_cfg: APB register file holding the height range (min and max).
// Depends on hjc_pkg.
module hjc_cfg import hjc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output height_t               height_min,
	output height_t               height_max
);

	height_t hmin_q;
	height_t hmax_q;
	logic    wr_en;
	logic    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[2];

	// Register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hmin_q <= HEIGHT_MIN_RST;
			hmax_q <= HEIGHT_MAX_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HEIGHT_MIN: hmin_q <= pwdata[HEIGHT_BITS-1:0];
				REG_HEIGHT_MAX: hmax_q <= pwdata[HEIGHT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read mux, sign extended to the bus
	always_comb begin
		case (reg_idx)
			REG_HEIGHT_MIN: prdata = 32'(hmin_q);
			REG_HEIGHT_MAX: prdata = 32'(hmax_q);
			default:        prdata = '0;
		endcase
	end

	assign height_min = hmin_q;
	assign height_max = hmax_q;

endmodule

/* rtl/hjc_front.sv */
// hjc_front: four pipeline stages that clamp the height, pick the ramp segment
// and form the divider numerator. Depends on hjc_pkg.
module hjc_front import hjc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  height_t height_min,
	input  height_t height_max,
	input  logic    in_valid,
	output logic    in_ready,
	input  height_t height_raw,
	output logic    out_valid,
	input  logic    out_ready,
	output cell_t   out_data
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	height_t                vc_s1;
	logic                   err_s1, err_s2, err_s3;
	logic [HEIGHT_BITS-1:0] d_s2, dv_s2, dv_s3;
	seg_t                   seg_s3;
	logic [WIDE_BITS-1:0]   n_s3;
	logic [NUM_BITS-1:0]    mdv_s3;
	cell_t                  cell_s4;

	// Stage handshake: a stage loads when empty or when it drains this cycle
	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: clamp to [min, max], flag a range with max <= min
	height_t vc;
	always_comb begin
		vc = height_raw;
		if (height_raw < height_min) vc = height_min;
		if (vc > height_max)         vc = height_max;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			vc_s1  <= vc;
			err_s1 <= (height_max <= height_min);
		end
	end

	// Stage 2: offsets d = v - min and dv = max - min
	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			d_s2   <= vc_s1 - height_min;
			dv_s2  <= height_max - height_min;
			err_s2 <= err_s1;
		end
	end

	// Stage 3: segment from 4d against dv, 2dv, 3dv; n = 4*M*d; M*dv
	logic [HEIGHT_BITS+1:0] d4, dv1, dv2, dv3;
	logic [WIDE_BITS-1:0]   dw;
	logic [NUM_BITS-1:0]    dvw;
	seg_t                   seg;
	always_comb begin
		d4  = {d_s2, 2'b00};
		dv1 = {2'b00, dv_s2};
		dv2 = {1'b0, dv_s2, 1'b0};
		dv3 = dv1 + dv2;
		if (d4 < dv1)      seg = SEG_RISE_G;
		else if (d4 < dv2) seg = SEG_FALL_B;
		else if (d4 < dv3) seg = SEG_RISE_R;
		else               seg = SEG_FALL_G;
		dw  = WIDE_BITS'(d_s2);
		dvw = NUM_BITS'(dv_s2);
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			seg_s3 <= seg;
			n_s3   <= (dw << (COLOR_BITS + 2)) - (dw << 2);
			mdv_s3 <= (dvw << COLOR_BITS) - dvw;
			dv_s3  <= dv_s2;
			err_s3 <= err_s2;
		end
	end

	// Stage 4: segment numerator, always below M*dv + 1
	logic [WIDE_BITS-1:0] mw, num_w;
	logic [NUM_BITS-1:0]  num;
	always_comb begin
		mw = WIDE_BITS'(mdv_s3);
		case (seg_s3)
			SEG_RISE_G: num_w = n_s3;
			SEG_FALL_B: num_w = (mw << 1) - n_s3;
			SEG_RISE_R: num_w = n_s3 - (mw << 1);
			default:    num_w = (mw << 2) - n_s3;
		endcase
		num = num_w[NUM_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			cell_s4.rem    <= num[NUM_BITS-1:COLOR_BITS];
			cell_s4.num_lo <= num[COLOR_BITS-1:0];
			cell_s4.dv     <= dv_s3;
			cell_s4.quo    <= '0;
			cell_s4.seg    <= seg_s3;
			cell_s4.err    <= err_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = cell_s4;

endmodule

/* rtl/hjc_div_cell.sv */
// hjc_div_cell: one restoring-division cell; settles one quotient bit per beat
// and hands the partial remainder to the next cell. Depends on hjc_pkg.
module hjc_div_cell import hjc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  cell_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output cell_t out_data
);

	logic                 v_q;
	cell_t                data_q;
	logic [HEIGHT_BITS:0] trial;
	logic [HEIGHT_BITS:0] diff;
	logic                 ge;
	cell_t                nxt;

	assign in_ready = !v_q || out_ready;

	// Shift in the next numerator bit, subtract dv when it fits
	always_comb begin
		trial      = {in_data.rem, in_data.num_lo[COLOR_BITS-1]};
		diff       = trial - {1'b0, in_data.dv};
		ge         = trial >= {1'b0, in_data.dv};
		nxt        = in_data;
		nxt.rem    = ge ? diff[HEIGHT_BITS-1:0] : trial[HEIGHT_BITS-1:0];
		nxt.num_lo = {in_data.num_lo[COLOR_BITS-2:0], 1'b0};
		nxt.quo    = {in_data.quo[COLOR_BITS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign out_data  = data_q;

endmodule

/* rtl/height_to_jet_color_unit.sv */
// height_to_jet_color_unit: top level; APB registers, front-end stages, a row of
// divider cells and the color output register. Depends on hjc_pkg, hjc_if,
// hjc_cfg, hjc_front and hjc_div_cell.
//
// Usage:
//   height_in carries one signed raw height per beat; color_out returns one
//   beat per input with red, green and blue levels (65535 is full) and
//   range_error, in input order. The APB port holds height_min (offset 0)
//   and height_max (offset 4); write them only while the unit is empty.
//   An input beat passes 4 front-end stages (clamp, offsets, segment and
//   products, numerator), 16 divider cells (one quotient bit each) and the
//   output register before output valid. Throughput is one beat per cycle
//   when not stalled; every stage has its own valid bit, so bubbles close up.
//   A stalled receiver holds the output beat steady; stages upstream keep
//   filling until the pipeline is full, then height_in.ready drops.
//   Reset clears all valid bits and loads min = 0, max = 65535.
//   When max <= min the colors are zero and range_error is set.
module height_to_jet_color_unit import hjc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	hjc_height_if.sink            height_in,
	hjc_color_if.source           color_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	height_t hmin;
	height_t hmax;

	hjc_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.height_min (hmin),
		.height_max (hmax)
	);

	// Cell chain links; link 0 comes from the front end
	cell_t cd [0:COLOR_BITS];
	logic  cv [0:COLOR_BITS];
	logic  cr [0:COLOR_BITS];

	hjc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.height_min (hmin),
		.height_max (hmax),
		.in_valid   (height_in.valid),
		.in_ready   (height_in.ready),
		.height_raw (height_in.height_raw),
		.out_valid  (cv[0]),
		.out_ready  (cr[0]),
		.out_data   (cd[0])
	);

	for (genvar k = 0; k < COLOR_BITS; k++) begin : g_cell
		hjc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv[k]),
			.in_ready  (cr[k]),
			.in_data   (cd[k]),
			.out_valid (cv[k+1]),
			.out_ready (cr[k+1]),
			.out_data  (cd[k+1])
		);
	end

	// Output register
	logic   out_v_q;
	color_t red_q, green_q, blue_q;
	logic   err_q;
	color_t red_c, green_c, blue_c;
	cell_t  last;

	assign last = cd[COLOR_BITS];
	assign cr[COLOR_BITS] = !out_v_q || color_out.ready;

	// Place the quotient in the segment's ramp channel
	always_comb begin
		case (last.seg)
			SEG_RISE_G: begin
				red_c = '0;        green_c = last.quo;  blue_c = COLOR_MAX;
			end
			SEG_FALL_B: begin
				red_c = '0;        green_c = COLOR_MAX; blue_c = last.quo;
			end
			SEG_RISE_R: begin
				red_c = last.quo;  green_c = COLOR_MAX; blue_c = '0;
			end
			default: begin
				red_c = COLOR_MAX; green_c = last.quo;  blue_c = '0;
			end
		endcase
		if (last.err) begin
			red_c   = '0;
			green_c = '0;
			blue_c  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cr[COLOR_BITS]) begin
			out_v_q <= cv[COLOR_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (cr[COLOR_BITS]) begin
			red_q   <= red_c;
			green_q <= green_c;
			blue_q  <= blue_c;
			err_q   <= last.err;
		end
	end

	assign color_out.valid       = out_v_q;
	assign color_out.red_level   = red_q;
	assign color_out.green_level = green_q;
	assign color_out.blue_level  = blue_q;
	assign color_out.range_error = err_q;

endmodule

/* rtl/hjc_checker.sv */
// hjc_checker: port-level assertions for height_to_jet_color_unit, bound to it.
// Depends on hjc_pkg and the top level's ports.
module hjc_checker import hjc_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   out_valid,
	input logic   out_ready,
	input color_t red,
	input color_t green,
	input color_t blue,
	input logic   err
);

	// Nothing leaves during reset; checked in the next cycle so the reset has taken hold
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

	// A stalled output beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({red, green, blue, err}))
		else $error("output beat changed while stalled");

	// A range error (max <= min) gives black
	a_err_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && err |-> red == '0 && green == '0 && blue == '0)
		else $error("range error with nonzero color");

	// Jet ramp: one channel full, red and blue never both lit
	a_jet_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !err |->
			(red == COLOR_MAX || green == COLOR_MAX || blue == COLOR_MAX) &&
			(red == '0 || blue == '0))
		else $error("color off the jet ramp");

endmodule

bind height_to_jet_color_unit hjc_checker u_hjc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (color_out.valid),
	.out_ready (color_out.ready),
	.red       (color_out.red_level),
	.green     (color_out.green_level),
	.blue      (color_out.blue_level),
	.err       (color_out.range_error)
);
